### sv/tafr_pkg.sv
// Shared types, constants and helpers for the two-angle frame rotator.
// No dependencies.
package tafr_pkg;

    localparam int COORD_W      = 32;   // Q16.16 coordinates
    localparam int CELL_W       = 34;   // rotated values stay below 2**33 in magnitude
    localparam int ANGLE_W      = 16;   // Q3.13 angles
    localparam int ANGLE_FRAC   = 13;
    localparam int WORK_FRAC    = 44;   // series accumulates in Q.44
    localparam int SERIES_PAIRS = 24;
    localparam int TERM_W       = 50;   // largest series term is below 2**49
    localparam int SUM_W        = 52;
    localparam int DIVISOR_W    = 6;
    localparam int MAX_DIVISOR  = 2 * SERIES_PAIRS + 1;
    localparam int PAIR_W       = 5;
    localparam int DIV_CNT_W    = $clog2(TERM_W);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [0:0] {
        REG_TILT = 1'b0,
        REG_LON  = 1'b1
    } tafr_reg_t;

    typedef struct packed {
        logic                  we;
        tafr_reg_t             index;
        logic [ANGLE_W-1:0]    data;
    } tafr_cfg_t;

    typedef enum logic [1:0] {
        TRIG_IDLE,
        TRIG_MUL,
        TRIG_DIV,
        TRIG_ROUND
    } tafr_trig_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] val;
        logic                      ovf;
    } tafr_sat_t;

    function automatic tafr_sat_t sat_coord(input logic signed [CELL_W-1:0] v);
        tafr_sat_t r;
        logic      fits;
        fits  = (&v[CELL_W-1:COORD_W-1]) || (~|v[CELL_W-1:COORD_W-1]);
        r.ovf = !fits;
        if (fits)
        begin
            r.val = v[COORD_W-1:0];
        end
        else
        begin
            r.val = v[CELL_W-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

endpackage

### sv/tafr_in_if.sv
// Input channel: one vector word plus direction.
// Depends on tafr_pkg.
interface tafr_in_if
    import tafr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;

    modport source (output valid, op, in_x, in_y, in_z, input ready);
    modport sink   (input valid, op, in_x, in_y, in_z, output ready);
endinterface

### sv/tafr_out_if.sv
// Output channel: rotated vector word plus saturation flag.
// Depends on tafr_pkg.
interface tafr_out_if
    import tafr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      overflow;

    modport source (output valid, out_x, out_y, out_z, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

### sv/two_angle_frame_rotator_top.sv
// Throughput one word per cycle while the result is taken and no angle recompute is pending.
// Two rotation cells of three stages each, then a saturating output register.
// A tilt or longitude write recomputes that angle's sine and cosine serially:
// 24 term pairs and a bit-serial divide per term for each angle written;
// the input is held off meanwhile. Reset: angles 0, cos 1.0, sin 0, pipeline empty.
module two_angle_frame_rotator_top
    import tafr_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [ANGLE_W-1:0] cfg_data,
    tafr_in_if.sink            vec,
    tafr_out_if.source         res
);

    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int SIDE0_W = COORD_W + 1;
    localparam int SIDE1_W = CELL_W + 1;

    tafr_cfg_t                cfg;
    logic                     trig_ready;
    logic signed [TRIG_W-1:0] cos_tilt, sin_tilt, cos_lon, sin_lon;

    logic                     c0_in_valid, c0_in_ready, c0_out_valid;
    logic signed [CELL_W-1:0] c0_a, c0_b, c0_p, c0_q;
    logic signed [TRIG_W-1:0] c0_c, c0_s;
    logic [SIDE0_W-1:0]       c0_side, c0_out_side;

    logic                     c1_in_ready, c1_out_valid, c1_out_ready;
    logic signed [CELL_W-1:0] c1_a, c1_p, c1_q;
    logic signed [TRIG_W-1:0] c1_c, c1_s;
    logic                     c1_op;
    logic [SIDE1_W-1:0]       c1_side, c1_out_side;

    logic                     fin_op;
    logic signed [CELL_W-1:0] fin_carry, fin_x, fin_y, fin_z;
    tafr_sat_t                sx, sy, sz;

    logic                      res_valid_reg;
    logic signed [COORD_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic                      res_ovf_reg;

    assign cfg = '{we: cfg_we, index: tafr_reg_t'(cfg_index), data: cfg_data};

    tafr_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .ready    (trig_ready),
        .cos_tilt (cos_tilt),
        .sin_tilt (sin_tilt),
        .cos_lon  (cos_lon),
        .sin_lon  (sin_lon)
    );

    // forward: tilt on (x, z), y carried; inverse: longitude on (x, y), z carried
    assign c0_in_valid = vec.valid && trig_ready;
    assign vec.ready   = c0_in_ready && trig_ready;
    assign c0_a        = CELL_W'(vec.in_x);
    assign c0_b        = vec.op ? CELL_W'(vec.in_y) : CELL_W'(vec.in_z);
    assign c0_c        = vec.op ? cos_lon : cos_tilt;
    assign c0_s        = vec.op ? sin_lon : sin_tilt;
    assign c0_side     = {vec.op, (vec.op ? vec.in_z : vec.in_y)};

    tafr_rot_cell #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .SIDE_W         (SIDE0_W)
    ) u_cell0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c0_in_valid),
        .in_ready  (c0_in_ready),
        .a         (c0_a),
        .b         (c0_b),
        .c         (c0_c),
        .s         (c0_s),
        .side      (c0_side),
        .out_valid (c0_out_valid),
        .out_ready (c1_in_ready),
        .p         (c0_p),
        .q         (c0_q),
        .out_side  (c0_out_side)
    );

    // second cell: (carried, t) through the other angle
    assign c1_op   = c0_out_side[SIDE0_W-1];
    assign c1_a    = CELL_W'($signed(c0_out_side[COORD_W-1:0]));
    assign c1_c    = c1_op ? cos_tilt : cos_lon;
    assign c1_s    = c1_op ? sin_tilt : sin_lon;
    assign c1_side = {c1_op, c0_q};

    tafr_rot_cell #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .SIDE_W         (SIDE1_W)
    ) u_cell1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c0_out_valid),
        .in_ready  (c1_in_ready),
        .a         (c1_a),
        .b         (c0_p),
        .c         (c1_c),
        .s         (c1_s),
        .side      (c1_side),
        .out_valid (c1_out_valid),
        .out_ready (c1_out_ready),
        .p         (c1_p),
        .q         (c1_q),
        .out_side  (c1_out_side)
    );

    assign fin_op    = c1_out_side[SIDE1_W-1];
    assign fin_carry = $signed(c1_out_side[CELL_W-1:0]);
    assign fin_x     = c1_q;
    assign fin_y     = fin_op ? fin_carry : c1_p;
    assign fin_z     = fin_op ? c1_p : fin_carry;

    assign sx = sat_coord(fin_x);
    assign sy = sat_coord(fin_y);
    assign sz = sat_coord(fin_z);

    assign c1_out_ready = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (c1_out_ready)
        begin
            res_valid_reg <= c1_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c1_out_ready)
        begin
            res_x_reg   <= sx.val;
            res_y_reg   <= sy.val;
            res_z_reg   <= sz.val;
            res_ovf_reg <= sx.ovf | sy.ovf | sz.ovf;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.out_x    = res_x_reg;
    assign res.out_y    = res_y_reg;
    assign res.out_z    = res_z_reg;
    assign res.overflow = res_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.overflow) |->
            (res.out_x == COORD_MAX || res.out_x == COORD_MIN ||
             res.out_y == COORD_MAX || res.out_y == COORD_MIN ||
             res.out_z == COORD_MAX || res.out_z == COORD_MIN))
        else $error("overflow flagged without a saturated coordinate");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !vec.ready)
        else $error("input taken while sine and cosine are stale");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid_reg ##1 res_valid_reg) |-> $past(c1_out_valid))
        else $error("result word without a word from the last cell");

endmodule

### sv/tafr_trig.sv
// Angle registers and serial sine/cosine unit (Taylor series, shared divider).
// Depends on tafr_pkg.
module tafr_trig
    import tafr_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tafr_cfg_t                        cfg,
    output logic                             ready,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_tilt,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_tilt,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_lon,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_lon
);

    localparam int TRIG_W    = TRIG_FRAC_BITS + 2;
    localparam int RND_SH    = WORK_FRAC - TRIG_FRAC_BITS;
    localparam int PROD_W    = TERM_W + ANGLE_W;
    localparam int SIN_SHIFT = WORK_FRAC - ANGLE_FRAC;

    localparam logic [TERM_W-1:0] COS_START = {{(TERM_W-1){1'b0}}, 1'b1} << WORK_FRAC;
    localparam logic [SUM_W:0]    RND_HALF  = {{SUM_W{1'b0}}, 1'b1} << (RND_SH - 1);
    localparam logic [SUM_W:0]    RND_ONE   = {{SUM_W{1'b0}}, 1'b1} << TRIG_FRAC_BITS;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE =
        {{(TRIG_W-1){1'b0}}, 1'b1} << TRIG_FRAC_BITS;

    tafr_trig_state_t          state_reg, state_next;
    logic [1:0]                dirty_reg, dirty_next, dirty_clr;
    logic signed [ANGLE_W-1:0] tilt_reg, lon_reg;
    tafr_reg_t                 sel_reg, sel_next;
    logic                      odd_reg, odd_next;
    logic                      aneg_reg, aneg_next;
    logic [ANGLE_W-1:0]        x_reg, x_next;
    logic [TERM_W-1:0]         term_reg, term_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [DIVISOR_W-1:0]      divisor_reg, divisor_next;
    logic [PAIR_W-1:0]         pair_reg, pair_next;
    logic                      half_reg, half_next;
    logic [TERM_W-1:0]         quo_reg, quo_next;
    logic [DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [TRIG_W-1:0]  cos_tilt_reg, cos_tilt_next;
    logic signed [TRIG_W-1:0]  sin_tilt_reg, sin_tilt_next;
    logic signed [TRIG_W-1:0]  cos_lon_reg, cos_lon_next;
    logic signed [TRIG_W-1:0]  sin_lon_reg, sin_lon_next;

    tafr_reg_t                 tgt;
    logic signed [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0]        start_mag;
    logic [PROD_W-1:0]         prod;
    logic [TERM_W-1:0]         dividend;
    logic [DIVISOR_W:0]        trial, trial_diff;
    logic                      take;
    logic [DIVISOR_W-1:0]      rem_step;
    logic [TERM_W-1:0]         quo_step;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W:0]            rnd;
    logic [TRIG_W-1:0]         trig_mag;
    logic signed [TRIG_W-1:0]  trig_val;
    logic                      trig_neg;

    // angle pick: tilt first when both are pending
    assign tgt         = dirty_reg[REG_TILT] ? REG_TILT : REG_LON;
    assign start_angle = (tgt == REG_TILT) ? tilt_reg : lon_reg;
    assign start_mag   = start_angle[ANGLE_W-1] ? (~start_angle + 1'b1) : start_angle;

    // term * |a| / (8192 * d) == ((term * |a|) >> 13) / d
    assign prod     = PROD_W'(term_reg) * PROD_W'(x_reg);
    assign dividend = prod[ANGLE_FRAC +: TERM_W];

    // restoring divider, one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[TERM_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign take       = (trial >= {1'b0, divisor_reg});
    assign rem_step   = take ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    assign quo_step   = {quo_reg[TERM_W-2:0], take};

    // magnitude rounded half away from zero, clamped to 1.0
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rnd      = ({1'b0, sum_mag} + RND_HALF) >> RND_SH;
    assign trig_mag = (rnd > RND_ONE) ? RND_ONE[TRIG_W-1:0] : rnd[TRIG_W-1:0];
    assign trig_neg = sum_reg[SUM_W-1] ^ (odd_reg & aneg_reg);
    assign trig_val = trig_neg ? -$signed(trig_mag) : $signed(trig_mag);

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        odd_next      = odd_reg;
        aneg_next     = aneg_reg;
        x_next        = x_reg;
        term_next     = term_reg;
        sum_next      = sum_reg;
        divisor_next  = divisor_reg;
        pair_next     = pair_reg;
        half_next     = half_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        cos_tilt_next = cos_tilt_reg;
        sin_tilt_next = sin_tilt_reg;
        cos_lon_next  = cos_lon_reg;
        sin_lon_next  = sin_lon_reg;
        dirty_clr     = '0;

        unique case (state_reg)
            TRIG_IDLE:
            begin
                if (dirty_reg != '0)
                begin
                    dirty_clr[tgt] = 1'b1;
                    sel_next       = tgt;
                    x_next         = start_mag;
                    aneg_next      = start_angle[ANGLE_W-1];
                    odd_next       = 1'b0;
                    term_next      = COS_START;
                    sum_next       = $signed({{(SUM_W-TERM_W){1'b0}}, COS_START});
                    divisor_next   = DIVISOR_W'(1);
                    pair_next      = PAIR_W'(1);
                    half_next      = 1'b0;
                    state_next     = TRIG_MUL;
                end
            end
            TRIG_MUL:
            begin
                quo_next   = dividend;
                rem_next   = '0;
                cnt_next   = DIV_CNT_W'(TERM_W - 1);
                state_next = TRIG_DIV;
            end
            TRIG_DIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    term_next    = quo_step;
                    divisor_next = divisor_reg + 1'b1;
                    half_next    = !half_reg;
                    state_next   = TRIG_MUL;
                    if (half_reg)
                    begin
                        // odd pairs subtract, even pairs add
                        if (pair_reg[0])
                        begin
                            sum_next = sum_reg - $signed({{(SUM_W-TERM_W){1'b0}}, quo_step});
                        end
                        else
                        begin
                            sum_next = sum_reg + $signed({{(SUM_W-TERM_W){1'b0}}, quo_step});
                        end
                        pair_next = pair_reg + 1'b1;
                        if (pair_reg == PAIR_W'(SERIES_PAIRS))
                        begin
                            state_next = TRIG_ROUND;
                        end
                    end
                end
            end
            TRIG_ROUND:
            begin
                priority if (sel_reg == REG_TILT && odd_reg)
                begin
                    sin_tilt_next = trig_val;
                end
                else if (sel_reg == REG_TILT)
                begin
                    cos_tilt_next = trig_val;
                end
                else if (odd_reg)
                begin
                    sin_lon_next = trig_val;
                end
                else
                begin
                    cos_lon_next = trig_val;
                end

                if (!odd_reg)
                begin
                    odd_next     = 1'b1;
                    term_next    = TERM_W'(x_reg) << SIN_SHIFT;
                    sum_next     = $signed(SUM_W'(x_reg) << SIN_SHIFT);
                    divisor_next = DIVISOR_W'(2);
                    pair_next    = PAIR_W'(1);
                    half_next    = 1'b0;
                    state_next   = TRIG_MUL;
                end
                else
                begin
                    state_next = TRIG_IDLE;
                end
            end
            default:
            begin
                state_next = TRIG_IDLE;
            end
        endcase

        // a write during a recompute marks the angle again
        dirty_next = dirty_reg & ~dirty_clr;
        if (cfg.we)
        begin
            dirty_next[cfg.index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= TRIG_IDLE;
            dirty_reg    <= '0;
            tilt_reg     <= '0;
            lon_reg      <= '0;
            cos_tilt_reg <= TRIG_ONE;
            sin_tilt_reg <= '0;
            cos_lon_reg  <= TRIG_ONE;
            sin_lon_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dirty_reg    <= dirty_next;
            cos_tilt_reg <= cos_tilt_next;
            sin_tilt_reg <= sin_tilt_next;
            cos_lon_reg  <= cos_lon_next;
            sin_lon_reg  <= sin_lon_next;
            if (cfg.we && cfg.index == REG_TILT)
            begin
                tilt_reg <= $signed(cfg.data);
            end
            if (cfg.we && cfg.index == REG_LON)
            begin
                lon_reg <= $signed(cfg.data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        odd_reg     <= odd_next;
        aneg_reg    <= aneg_next;
        x_reg       <= x_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
        divisor_reg <= divisor_next;
        pair_reg    <= pair_next;
        half_reg    <= half_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
    end

    assign ready    = (state_reg == TRIG_IDLE) && (dirty_reg == '0);
    assign cos_tilt = cos_tilt_reg;
    assign sin_tilt = sin_tilt_reg;
    assign cos_lon  = cos_lon_reg;
    assign sin_lon  = sin_lon_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TRIG_IDLE && state_next != TRIG_IDLE) |-> dirty_reg != '0)
        else $error("trig unit started without a pending angle");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == TRIG_DIV |-> rem_reg < divisor_reg)
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == TRIG_DIV |->
            (divisor_reg != '0 && divisor_reg <= DIVISOR_W'(MAX_DIVISOR)))
        else $error("series divisor out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cos_tilt_reg <= TRIG_ONE && cos_tilt_reg >= -TRIG_ONE &&
         sin_lon_reg <= TRIG_ONE && sin_lon_reg >= -TRIG_ONE))
        else $error("trig value beyond unity");

endmodule

### sv/tafr_rot_cell.sv
// Plane rotation cell: p = a*c + b*s, q = b*c - a*s, rounded; three stages.
// Depends on tafr_pkg.
module tafr_rot_cell
    import tafr_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 16,
    parameter int SIDE_W         = 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [CELL_W-1:0]         a,
    input  logic signed [CELL_W-1:0]         b,
    input  logic signed [TRIG_FRAC_BITS+1:0] c,
    input  logic signed [TRIG_FRAC_BITS+1:0] s,
    input  logic [SIDE_W-1:0]                side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [CELL_W-1:0]         p,
    output logic signed [CELL_W-1:0]         q,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W = CELL_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

    logic                      v1_reg, v2_reg, v3_reg;
    logic                      rdy1, rdy2, rdy3;
    logic signed [PROD_W-1:0]  m_ac, m_bs, m_bc, m_as;
    logic signed [PROD_W-1:0]  m_ac_reg, m_bs_reg, m_bc_reg, m_as_reg;
    logic [SIDE_W-1:0]         side1_reg, side2_reg, side3_reg;
    logic signed [ACC_W-1:0]   sp_next, sq_next, sp_reg, sq_reg;
    logic signed [ACC_W-1:0]   rp_biased, rq_biased;
    logic signed [CELL_W-1:0]  p_next, q_next, p_reg, q_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign m_ac = a * c;
    assign m_bs = b * s;
    assign m_bc = b * c;
    assign m_as = a * s;

    assign sp_next = ACC_W'(m_ac_reg) + ACC_W'(m_bs_reg);
    assign sq_next = ACC_W'(m_bc_reg) - ACC_W'(m_as_reg);

    // half away from zero: floor((v + half - neg) / 2**F)
    assign rp_biased = sp_reg + RND_HALF - ACC_W'(sp_reg[ACC_W-1]);
    assign rq_biased = sq_reg + RND_HALF - ACC_W'(sq_reg[ACC_W-1]);
    assign p_next    = rp_biased[TRIG_FRAC_BITS +: CELL_W];
    assign q_next    = rq_biased[TRIG_FRAC_BITS +: CELL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            m_ac_reg  <= m_ac;
            m_bs_reg  <= m_bs;
            m_bc_reg  <= m_bc;
            m_as_reg  <= m_as;
            side1_reg <= side;
        end
        if (rdy2)
        begin
            sp_reg    <= sp_next;
            sq_reg    <= sq_next;
            side2_reg <= side1_reg;
        end
        if (rdy3)
        begin
            p_reg     <= p_next;
            q_reg     <= q_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign p         = p_reg;
    assign q         = q_reg;
    assign out_side  = side3_reg;

endmodule
